FILE: hw/rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Types and constants shared by the water sampling sequencer.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int THRESH_W  = 12;
  localparam int TMR_N     = 5;
  localparam int TMR_IDX_W = 3;

  // command codes
  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_INIT  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_FWD  = 2'd1,
    MOTOR_REV  = 2'd2
  } motor_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_OFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;

  // timer slots
  localparam logic [TMR_IDX_W-1:0] T_FILL   = 3'd0;
  localparam logic [TMR_IDX_W-1:0] T_BAL    = 3'd1;
  localparam logic [TMR_IDX_W-1:0] T_MOFF   = 3'd2;
  localparam logic [TMR_IDX_W-1:0] T_DISCH  = 3'd3;
  localparam logic [TMR_IDX_W-1:0] T_SETTLE = 3'd4;

  localparam logic [CFG_W-1:0]    FILL_RST      = 16'd8000;
  localparam logic [CFG_W-1:0]    BALANCE_RST   = 16'd8000;
  localparam logic [CFG_W-1:0]    MOTOR_OFF_RST = 16'd2000;
  localparam logic [CFG_W-1:0]    DISCHARGE_RST = 16'd2000;
  localparam logic [CFG_W-1:0]    SETTLE_RST    = 16'd100;
  localparam logic [THRESH_W-1:0] THRESHOLD_RST = 12'd100;

  typedef struct packed {
    logic [CFG_W-1:0]    fill_time_ms;
    logic [CFG_W-1:0]    balance_time_ms;
    logic [CFG_W-1:0]    motor_off_time_ms;
    logic [CFG_W-1:0]    discharge_time_ms;
    logic [CFG_W-1:0]    settle_time_ms;
    logic [THRESH_W-1:0] clamp_threshold;
  } cfg_t;

  typedef struct packed {
    logic   charge;
    logic   balance;
    logic   discharge;
    logic   settle;
    logic   motor;
    logic   complete;
    logic   pump;
    logic   suction;
    logic   blow;
    motor_t drive;
  } seq_state_t;

  localparam seq_state_t STATE_OFF = '{
    charge: 1'b0, balance: 1'b0, discharge: 1'b0, settle: 1'b0,
    motor: 1'b0, complete: 1'b0, pump: 1'b0, suction: 1'b0, blow: 1'b0,
    drive: MOTOR_STOP
  };

endpackage

FILE: hw/rtl/wss_if.sv
// ----------------------------------------------------------------------------
// wss_if
// Valid/ready channels of the water sampling sequencer.
// ----------------------------------------------------------------------------
interface wss_in_if #(
  parameter int SENSOR_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic                   full_switch;
  logic [SENSOR_BITS-1:0] clamp_reading;

  modport source (output valid, cmd, full_switch, clamp_reading, input ready);
  modport sink (input valid, cmd, full_switch, clamp_reading, output ready);
endinterface

interface wss_out_if;
  logic       valid;
  logic       ready;
  logic       pump_on;
  logic       suction_valve_on;
  logic       blow_valve_on;
  logic [1:0] motor_drive;
  logic       sample_complete;

  modport source (output valid, pump_on, suction_valve_on, blow_valve_on,
                  motor_drive, sample_complete, input ready);
  modport sink (input valid, pump_on, suction_valve_on, blow_valve_on,
                motor_drive, sample_complete, output ready);
endinterface

FILE: hw/rtl/water_sampling_sequencer.sv
// ----------------------------------------------------------------------------
// water_sampling_sequencer
// Pump, valve and clamp motor sequencer for a water sampler.
// ----------------------------------------------------------------------------
// req carries one command word: a one millisecond step, init or start,
// with the full switch and the clamp sensor reading sampled for that step.
// rsp returns one word per command with the actuator outputs and the
// complete flag as they stand after the command.
// cfg_we/cfg_index/cfg_data write the five phase times and the clamp
// threshold; writes take effect at once, and the user must make them only
// while the block idles; the block itself does not enforce it.
// A command is taken into an input register; the step logic updates the
// phase flags, actuators and five timers and loads the state and result
// registers. One word per cycle is sustained while rsp.ready stays high.
// When rsp stalls, the result register holds its word and the input
// register holds one more; req.ready drops once both are full.
// Reset clears flags, actuators and timers, loads the register defaults
// and empties both pipeline registers; req.ready is low during reset.
// ----------------------------------------------------------------------------
module water_sampling_sequencer
  import wss_pkg::*;
#(
  parameter int TIMER_BITS  = 16,
  parameter int SENSOR_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  wss_in_if.sink               req,
  wss_out_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t                             cfg;
  logic                             in_valid;
  logic [1:0]                       in_cmd;
  logic                             in_full;
  logic [SENSOR_BITS-1:0]           in_reading;
  seq_state_t                       state;
  seq_state_t                       state_next;
  logic [TMR_N-1:0][TIMER_BITS-1:0] timers;
  logic [TMR_N-1:0][TIMER_BITS-1:0] timers_next;
  logic                             out_valid;
  logic                             advance;
  logic                             fire;

  wss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wss_step #(
    .TIMER_BITS  (TIMER_BITS),
    .SENSOR_BITS (SENSOR_BITS)
  ) u_step (
    .cmd           (in_cmd),
    .full_switch   (in_full),
    .clamp_reading (in_reading),
    .cfg           (cfg),
    .state         (state),
    .timers        (timers),
    .state_next    (state_next),
    .timers_next   (timers_next)
  );

  assign advance   = !out_valid || rsp.ready;
  assign fire      = in_valid && advance;
  assign req.ready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_cmd     <= req.cmd;
      in_full    <= req.full_switch;
      in_reading <= req.clamp_reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= STATE_OFF;
      timers <= '0;
    end else if (fire) begin
      state  <= state_next;
      timers <= timers_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.pump_on          <= state_next.pump;
      rsp.suction_valve_on <= state_next.suction;
      rsp.blow_valve_on    <= state_next.blow;
      rsp.motor_drive      <= state_next.drive;
      rsp.sample_complete  <= state_next.complete;
    end
  end

  assign rsp.valid = out_valid;

endmodule

FILE: hw/rtl/wss_cfg.sv
// ----------------------------------------------------------------------------
// wss_cfg
// Timing and threshold registers with their reset defaults.
// ----------------------------------------------------------------------------
module wss_cfg
  import wss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fill_time_ms      <= FILL_RST;
      cfg.balance_time_ms   <= BALANCE_RST;
      cfg.motor_off_time_ms <= MOTOR_OFF_RST;
      cfg.discharge_time_ms <= DISCHARGE_RST;
      cfg.settle_time_ms    <= SETTLE_RST;
      cfg.clamp_threshold   <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILL:      cfg.fill_time_ms      <= cfg_data;
        REG_BALANCE:   cfg.balance_time_ms   <= cfg_data;
        REG_MOTOR_OFF: cfg.motor_off_time_ms <= cfg_data;
        REG_DISCHARGE: cfg.discharge_time_ms <= cfg_data;
        REG_SETTLE:    cfg.settle_time_ms    <= cfg_data;
        REG_THRESHOLD: cfg.clamp_threshold   <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/wss_step.sv
// ----------------------------------------------------------------------------
// wss_step
// Next state of the sequencer for one command word.
// ----------------------------------------------------------------------------
module wss_step
  import wss_pkg::*;
#(
  parameter int TIMER_BITS  = 16,
  parameter int SENSOR_BITS = 12
) (
  input  logic [1:0]                        cmd,
  input  logic                              full_switch,
  input  logic [SENSOR_BITS-1:0]            clamp_reading,
  input  cfg_t                              cfg,
  input  seq_state_t                        state,
  input  logic [TMR_N-1:0][TIMER_BITS-1:0]  timers,
  output seq_state_t                        state_next,
  output logic [TMR_N-1:0][TIMER_BITS-1:0]  timers_next
);

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int RD_W  = (SENSOR_BITS > THRESH_W) ? SENSOR_BITS : THRESH_W;

  logic [TMR_N-1:0][TIMER_BITS-1:0] t_inc;
  logic                             clamped;

  function automatic logic expired(input logic [TIMER_BITS-1:0] t,
                                   input logic [CFG_W-1:0] limit);
    expired = CMP_W'(t) >= CMP_W'(limit);
  endfunction

  // saturating advance of every timer
  always_comb begin
    for (int i = 0; i < TMR_N; i++) begin
      t_inc[i] = (timers[i] == {TIMER_BITS{1'b1}}) ? timers[i] : timers[i] + 1'b1;
    end
  end

  assign clamped = RD_W'(clamp_reading) > RD_W'(cfg.clamp_threshold);

  // checks run in order, each one sees the updates of the ones above
  always_comb begin
    state_next  = state;
    timers_next = timers;
    case (cmd)
      CMD_STEP: begin
        timers_next = t_inc;
        if (full_switch || (state_next.charge &&
            expired(timers_next[T_FILL], cfg.fill_time_ms))) begin
          state_next.pump    = 1'b1;
          state_next.suction = 1'b0;
          state_next.blow    = 1'b1;
          state_next.charge  = 1'b0;
          state_next.balance = 1'b1;
          timers_next[T_BAL]  = '0;
          timers_next[T_MOFF] = '0;
        end
        if (state_next.balance &&
            expired(timers_next[T_BAL], cfg.balance_time_ms)) begin
          state_next.pump      = 1'b0;
          state_next.suction   = 1'b1;
          state_next.blow      = 1'b1;
          state_next.drive     = MOTOR_REV;
          state_next.balance   = 1'b0;
          state_next.discharge = 1'b1;
          timers_next[T_DISCH] = '0;
        end
        if (state_next.balance &&
            expired(timers_next[T_MOFF], cfg.motor_off_time_ms)) begin
          state_next.drive = MOTOR_STOP;
          state_next.motor = 1'b0;
        end
        if (state_next.discharge &&
            expired(timers_next[T_DISCH], cfg.discharge_time_ms)) begin
          state_next.drive     = MOTOR_STOP;
          state_next.discharge = 1'b0;
          state_next.settle    = 1'b1;
          timers_next[T_SETTLE] = '0;
        end
        if (state_next.settle &&
            expired(timers_next[T_SETTLE], cfg.settle_time_ms)) begin
          state_next.drive    = MOTOR_STOP;
          state_next.settle   = 1'b0;
          state_next.complete = 1'b1;
          state_next.suction  = 1'b0;
          state_next.blow     = 1'b1;
        end
        if (clamped && state_next.motor) begin
          state_next.pump    = 1'b1;
          state_next.suction = 1'b1;
          state_next.blow    = 1'b0;
          state_next.motor   = 1'b0;
          state_next.charge  = 1'b1;
          timers_next[T_FILL] = '0;
        end
      end
      CMD_INIT: begin
        state_next = STATE_OFF;
      end
      CMD_START: begin
        state_next.drive = MOTOR_FWD;
        state_next.motor = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/wss_checker.sv
// ----------------------------------------------------------------------------
// wss_checker
// Port-level checks of the water sampling sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module wss_checker
  import wss_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       pump_on,
  input logic       suction_valve_on,
  input logic       blow_valve_on,
  input logic [1:0] motor_drive,
  input logic       sample_complete
);

  logic [5:0] payload;

  assign payload = {pump_on, suction_valve_on, blow_valve_on, motor_drive,
                    sample_complete};

  // no word left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // a new response stems from a command accepted through the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("response without a command two cycles before");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload))
    else $error("stalled response changed");

  // no phase opens pump, suction and blow valve together
  a_no_all_on: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(pump_on && suction_valve_on && blow_valve_on))
    else $error("pump, suction and blow all on");

  a_motor_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (motor_drive == MOTOR_STOP || motor_drive == MOTOR_FWD ||
                   motor_drive == MOTOR_REV))
    else $error("bad motor drive code");

endmodule

bind water_sampling_sequencer wss_checker u_wss_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .pump_on          (rsp.pump_on),
  .suction_valve_on (rsp.suction_valve_on),
  .blow_valve_on    (rsp.blow_valve_on),
  .motor_drive      (rsp.motor_drive),
  .sample_complete  (rsp.sample_complete)
);
